// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define PEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("percent codec assertion failed");

// clocked property, checked during reset too
`define PEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("percent codec assertion failed");

`endif

// ----- src/pec_pkg.sv -----
// package for the percent escape codec: types, codes and byte classifiers
package pec_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_OUT    = 3;
    localparam int CNT_W      = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [BYTE_W-1:0] CH_PCT = 8'h25;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic REG_DIRECTION = 1'b0;

    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_PCT   = 2'd1,
        HOLD_DIGIT = 2'd2
    } t_hold;

    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               cnt;
        logic                           str_end;
    } t_cmd;

    typedef struct packed {
        logic we;
        logic dir;
    } t_cfg_wr;

    function automatic logic is_safe(input logic [BYTE_W-1:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          8'h24, 8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21,
                          8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C, 8'h3A});
    endfunction

    function automatic logic is_hex(input logic [BYTE_W-1:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
        logic [3:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        logic [BYTE_W-1:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h37 + {4'd0, n};
        end
        return c;
    endfunction

endpackage

// ----- src/pec_front.sv -----
// front end: direction register, escape state and per-item result planning
module pec_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_q_full,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_in_end,
    input  pec_pkg::t_cfg_wr       i_cfg,
    output logic                   o_q_push,
    output pec_pkg::t_cmd          o_cmd,
    output logic                   o_dir
);
    import pec_pkg::*;

    logic              r_dir;
    t_hold             r_hold;
    logic [BYTE_W-1:0] r_digit;
    t_hold             n_hold;
    logic [BYTE_W-1:0] n_digit;
    logic              accept;
    t_cmd              cmd;

    assign accept = i_push && !i_q_full;

    always_comb begin
        cmd         = '0;
        cmd.str_end = i_in_end;
        n_hold      = r_hold;
        n_digit     = r_digit;
        if (r_dir == DIR_ENCODE) begin
            if (is_safe(i_in_byte)) begin
                cmd.bytes[0] = i_in_byte;
                cmd.cnt      = 2'd1;
            end else begin
                cmd.bytes[0] = CH_PCT;
                cmd.bytes[1] = hex_char(i_in_byte[7:4]);
                cmd.bytes[2] = hex_char(i_in_byte[3:0]);
                cmd.cnt      = 2'd3;
            end
        end else begin
            case (r_hold)
                HOLD_PCT: begin
                    if (is_hex(i_in_byte)) begin
                        n_digit = i_in_byte;
                        n_hold  = HOLD_DIGIT;
                    end else begin
                        n_hold             = HOLD_NONE;
                        cmd.bytes[cmd.cnt] = CH_PCT;
                        cmd.cnt            = cmd.cnt + 2'd1;
                        if (i_in_byte == CH_PCT) begin
                            n_hold = HOLD_PCT;
                        end else begin
                            cmd.bytes[cmd.cnt] = i_in_byte;
                            cmd.cnt            = cmd.cnt + 2'd1;
                        end
                    end
                end
                HOLD_DIGIT: begin
                    n_hold = HOLD_NONE;
                    if (is_hex(r_digit) && is_hex(i_in_byte)) begin
                        cmd.bytes[cmd.cnt] = {hex_val(r_digit), hex_val(i_in_byte)};
                        cmd.cnt            = cmd.cnt + 2'd1;
                    end else begin
                        cmd.bytes[cmd.cnt] = CH_PCT;
                        cmd.cnt            = cmd.cnt + 2'd1;
                        cmd.bytes[cmd.cnt] = r_digit;
                        cmd.cnt            = cmd.cnt + 2'd1;
                        if (i_in_byte == CH_PCT) begin
                            n_hold = HOLD_PCT;
                        end else begin
                            cmd.bytes[cmd.cnt] = i_in_byte;
                            cmd.cnt            = cmd.cnt + 2'd1;
                        end
                    end
                    n_digit = '0;
                end
                default: begin
                    n_hold = HOLD_NONE;
                    if (i_in_byte == CH_PCT) begin
                        n_hold = HOLD_PCT;
                    end else begin
                        cmd.bytes[cmd.cnt] = i_in_byte;
                        cmd.cnt            = cmd.cnt + 2'd1;
                    end
                end
            endcase
            if (i_in_end) begin
                if (n_hold == HOLD_PCT) begin
                    cmd.bytes[cmd.cnt] = CH_PCT;
                    cmd.cnt            = cmd.cnt + 2'd1;
                end else if (n_hold == HOLD_DIGIT) begin
                    cmd.bytes[cmd.cnt] = CH_PCT;
                    cmd.cnt            = cmd.cnt + 2'd1;
                    cmd.bytes[cmd.cnt] = n_digit;
                    cmd.cnt            = cmd.cnt + 2'd1;
                end
            end
        end
        if (i_in_end) begin
            n_hold  = HOLD_NONE;
            n_digit = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_hold  <= HOLD_NONE;
            r_digit <= '0;
        end else if (i_cfg.we) begin
            r_dir   <= i_cfg.dir;
            r_hold  <= HOLD_NONE;
            r_digit <= '0;
        end else if (accept) begin
            r_hold  <= n_hold;
            r_digit <= n_digit;
        end
    end

    assign o_q_push = accept && (cmd.cnt != '0);
    assign o_cmd    = cmd;
    assign o_dir    = r_dir;

endmodule

// ----- src/pec_queue.sv -----
// short command queue between the front end and the output serializer
module pec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pec_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pec_pkg::t_cmd o_head
);
    import pec_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- src/pec_back.sv -----
// back end: walks the queued results one byte per cycle, while the output register is free or being popped, into it
module pec_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  pec_pkg::t_cmd i_q_head,
    output logic          o_q_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_out_end
);
    import pec_pkg::*;

    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_run_last;
    logic              r_out_end;
    logic              load;
    logic              last_byte;

    assign last_byte = (r_idx == i_q_head.cnt - 2'd1);
    assign load      = i_q_valid && (!r_out_valid || pop);
    assign o_q_pop   = load && last_byte;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_q_head.bytes[r_idx];
            r_run_last <= last_byte;
            r_out_end  <= last_byte && i_q_head.str_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= last_byte ? '0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_run_last;
    assign o_out_end  = r_out_end;

endmodule

// ----- src/percent_escape_codec.sv -----
// top level of the percent escape codec
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------
//  input    | push / full       | i_in_byte, i_in_end
//  result   | empty / pop       | o_out_byte, o_run_last, o_out_end
//  config   | psel/penable/...  | direction at byte address 0
//
// an item is taken while the queue is not full; its results leave at one byte per cycle
// while the result register is free or being popped: three bytes for an encoded escape,
// up to three for a broken decode escape, none for a decode byte that is only held
// the output serializer sets the sustained rate; a two-entry queue decouples it
// a full queue raises full; a held result register raises nothing upstream by itself
// synchronous active-low reset empties queue and output and selects encode
module percent_escape_codec (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_run_last,
    output logic                            o_out_end,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pec_pkg::*;

    t_cfg_wr cfg;
    t_cmd    f_cmd;
    t_cmd    q_head;
    logic    f_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    dir;

    assign pready  = 1'b1;
    assign cfg.we  = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
    assign cfg.dir = pwdata[0];
    assign prdata  = (paddr[2] == REG_DIRECTION) ? {{(APB_DATA_W-1){1'b0}}, dir} : '0;
    assign full    = q_full;

    pec_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_q_full  (q_full),
        .i_in_byte (i_in_byte),
        .i_in_end  (i_in_end),
        .i_cfg     (cfg),
        .o_q_push  (f_push),
        .o_cmd     (f_cmd),
        .o_dir     (dir)
    );

    pec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    pec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_out_end  (o_out_end)
    );

endmodule

// ----- src/pec_checker.sv -----
// port-level checker for the percent escape codec and its bind
`include "assert_macros.svh"

module pec_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            push,
    input logic                            full,
    input logic [7:0]                      i_in_byte,
    input logic                            i_in_end,
    input logic                            empty,
    input logic                            pop,
    input logic [7:0]                      o_out_byte,
    input logic                            o_run_last,
    input logic                            o_out_end,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [pec_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [pec_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [pec_pkg::APB_DATA_W-1:0]  prdata,
    input logic                            pready
);

    // end of string is always the last byte of its item
    `PEC_ASSERT(a_end_is_run_last, i_clk, i_rst_n, (!empty && o_out_end) |-> o_run_last)

    // reset leaves no result waiting
    `PEC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty)

    // config port never stalls
    `PEC_ASSERT_ALWAYS(a_pready_high, i_clk, pready)

    // a waiting result holds until taken
    `PEC_ASSERT(a_out_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_run_last) && $stable(o_out_end)))

endmodule

bind percent_escape_codec pec_checker u_pec_checker (.*);
